// File: hdl/gww_pkg.sv
// gww_pkg: shared types and constants of the greedy word wrap block
// word layouts of the request and response channels, character codes, register map
// no dependencies
package gww_pkg;

   localparam logic [7:0] SPACE_CODE   = 8'd32;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] NUL_CODE     = 8'd0;

   localparam int unsigned CSR_ADDR_W    = 3;
   localparam int unsigned CSR_DATA_W    = 32;
   localparam logic        REG_COLUMNS   = 1'b0;   // register index, taken from paddr[2]
   localparam logic [7:0]  COLUMNS_RESET = 8'd32;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic       line_valid;
      logic [1:0] line_number;
      logic [9:0] line_start;
      logic [7:0] line_length;
      logic [2:0] lines_total;
      logic       done_res;
   } rsp_type;

   // step unit to top level
   typedef struct packed {
      logic    has_rsp;
      rsp_type rsp;
   } step_out_type;

endpackage

// File: hdl/gww_csr.sv
// gww_csr: configuration register file (columns) behind the APB-style port
// depends on gww_pkg
module gww_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gww_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [gww_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [gww_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output logic [7:0]                     columns
);
   import gww_pkg::*;

   logic [7:0] columns_ff;
   logic [7:0] columns_in;
   logic       hit;

   assign hit     = (paddr[2] == REG_COLUMNS);
   assign pready  = 1'b1;
   assign columns = columns_ff;

   always_comb begin
      columns_in = columns_ff;
      if (psel && penable && pwrite && hit) begin
         columns_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
      end else begin
         columns_ff <= columns_in;
      end
   end

   assign prdata = hit ? {{(CSR_DATA_W-8){1'b0}}, columns_ff} : '0;

endmodule

// File: hdl/gww_step.sv
// gww_step: caption state and the per-character wrap decision
// one word per fire, state updated in the same cycle; depends on gww_pkg
module gww_step #(
   parameter int unsigned MAX_LINES    = 4,
   parameter int unsigned MAX_TEXT_LEN = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  gww_pkg::req_type      req,
   input  logic [7:0]            columns,
   output gww_pkg::step_out_type step_out
);
   import gww_pkg::*;

   localparam int unsigned TPW = $clog2(MAX_TEXT_LEN + 1);
   localparam int unsigned LNW = $clog2(MAX_LINES + 1);
   localparam logic [TPW-1:0] TEXT_END  = TPW'(MAX_TEXT_LEN);
   localparam logic [LNW-1:0] LINES_END = LNW'(MAX_LINES);

   logic           in_line_ff, in_line_in;
   logic [TPW-1:0] text_position_ff, text_position_in;
   logic [TPW-1:0] current_start_ff, current_start_in;
   logic [7:0]     current_length_ff, current_length_in;
   logic [7:0]     last_space_pos_ff, last_space_pos_in;
   logic           have_space_ff, have_space_in;
   logic [7:0]     end_before_space_ff, end_before_space_in;
   logic [7:0]     nonspace_end_ff, nonspace_end_in;
   logic           swallow_newline_ff, swallow_newline_in;
   logic [LNW-1:0] lines_emitted_ff, lines_emitted_in;

   logic           emit;
   logic [TPW-1:0] emit_start;
   logic [7:0]     emit_len;
   logic [7:0]     cols;
   logic           is_space;
   logic           is_newline;
   logic           blocked;

   assign cols       = (columns == 8'd0) ? 8'd1 : columns;
   assign is_space   = (req.char_code == SPACE_CODE);
   assign is_newline = (req.char_code == NEWLINE_CODE);
   assign blocked    = (lines_emitted_ff >= LINES_END) || (text_position_ff >= TEXT_END);

   always_comb begin
      in_line_in          = in_line_ff;
      text_position_in    = text_position_ff;
      current_start_in    = current_start_ff;
      current_length_in   = current_length_ff;
      last_space_pos_in   = last_space_pos_ff;
      have_space_in       = have_space_ff;
      end_before_space_in = end_before_space_ff;
      nonspace_end_in     = nonspace_end_ff;
      swallow_newline_in  = swallow_newline_ff;
      lines_emitted_in    = lines_emitted_ff;
      emit                = 1'b0;
      emit_start          = current_start_ff;
      emit_len            = nonspace_end_ff;
      step_out            = '0;

      if (fire && !req.end_of_text && !blocked) begin
         if (req.char_code == NUL_CODE) begin
            text_position_in = TEXT_END;
         end else begin
            text_position_in   = text_position_ff + 1'b1;
            swallow_newline_in = 1'b0;
            if (swallow_newline_ff && is_newline) begin
               // newline right after an edge space is consumed
            end else if (!in_line_ff) begin
               if (is_newline) begin
                  emit       = 1'b1;
                  emit_start = text_position_ff;
                  emit_len   = 8'd0;
               end else if (!is_space) begin
                  in_line_in          = 1'b1;
                  current_start_in    = text_position_ff;
                  current_length_in   = 8'd1;
                  nonspace_end_in     = 8'd1;
                  have_space_in       = 1'b0;
                  last_space_pos_in   = 8'd0;
                  end_before_space_in = 8'd0;
               end
            end else if (is_newline) begin
               emit       = 1'b1;
               in_line_in = 1'b0;
            end else if (current_length_ff < cols) begin
               current_length_in = current_length_ff + 1'b1;
               if (is_space) begin
                  end_before_space_in = nonspace_end_ff;
                  last_space_pos_in   = current_length_ff;
                  have_space_in       = 1'b1;
               end else begin
                  nonspace_end_in = current_length_ff + 1'b1;
               end
            end else if (is_space) begin
               // full line, space at the edge
               emit               = 1'b1;
               in_line_in         = 1'b0;
               swallow_newline_in = 1'b1;
            end else if (have_space_ff && (last_space_pos_ff != 8'd0)) begin
               // break at last space, unfinished word carries over
               emit                = 1'b1;
               emit_len            = end_before_space_ff;
               current_start_in    = current_start_ff + TPW'(last_space_pos_ff) + 1'b1;
               current_length_in   = current_length_ff - last_space_pos_ff;
               nonspace_end_in     = current_length_ff - last_space_pos_ff;
               have_space_in       = 1'b0;
               last_space_pos_in   = 8'd0;
               end_before_space_in = 8'd0;
            end else begin
               // no space: cut the word, this char opens the next line
               emit                = 1'b1;
               in_line_in          = 1'b1;
               current_start_in    = text_position_ff;
               current_length_in   = 8'd1;
               nonspace_end_in     = 8'd1;
               have_space_in       = 1'b0;
               last_space_pos_in   = 8'd0;
               end_before_space_in = 8'd0;
            end
         end
      end

      if (fire && req.end_of_text) begin
         emit              = in_line_ff && (lines_emitted_ff < LINES_END);
         step_out.has_rsp  = 1'b1;
         step_out.rsp.done_res    = 1'b1;
         step_out.rsp.lines_total = 3'(lines_emitted_ff);
      end

      if (emit) begin
         step_out.has_rsp          = 1'b1;
         step_out.rsp.line_valid   = 1'b1;
         step_out.rsp.line_number  = 2'(lines_emitted_ff);
         step_out.rsp.line_start   = 10'(emit_start);
         step_out.rsp.line_length  = emit_len;
         step_out.rsp.lines_total  = 3'(lines_emitted_ff + 1'b1);
         lines_emitted_in          = lines_emitted_ff + 1'b1;
      end

      if (fire && req.end_of_text) begin
         in_line_in          = 1'b0;
         text_position_in    = '0;
         current_start_in    = '0;
         current_length_in   = 8'd0;
         last_space_pos_in   = 8'd0;
         have_space_in       = 1'b0;
         end_before_space_in = 8'd0;
         nonspace_end_in     = 8'd0;
         swallow_newline_in  = 1'b0;
         lines_emitted_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_line_ff          <= 1'b0;
         text_position_ff    <= '0;
         current_start_ff    <= '0;
         current_length_ff   <= 8'd0;
         last_space_pos_ff   <= 8'd0;
         have_space_ff       <= 1'b0;
         end_before_space_ff <= 8'd0;
         nonspace_end_ff     <= 8'd0;
         swallow_newline_ff  <= 1'b0;
         lines_emitted_ff    <= '0;
      end else begin
         in_line_ff          <= in_line_in;
         text_position_ff    <= text_position_in;
         current_start_ff    <= current_start_in;
         current_length_ff   <= current_length_in;
         last_space_pos_ff   <= last_space_pos_in;
         have_space_ff       <= have_space_in;
         end_before_space_ff <= end_before_space_in;
         nonspace_end_ff     <= nonspace_end_in;
         swallow_newline_ff  <= swallow_newline_in;
         lines_emitted_ff    <= lines_emitted_in;
      end
   end

endmodule

// File: hdl/greedy_word_wrap.sv
// greedy_word_wrap: top level, input register, step unit and response register
// depends on gww_pkg, gww_csr, gww_step
//
//   channel | ports               | word
//   --------+---------------------+-------------------------------------
//   request | req_valid/req_ready | req_data: char_code, end_of_text
//   response| rsp_valid/rsp_ready | rsp_data: one line record
//   config  | psel..pready        | columns at byte address 0
//
// one word per cycle unless the response stalls: a word is held in the input register,
// then the step unit updates the caption state and loads the response register, so
// a record reaches rsp_valid through the input register and then the response register.
// reset clears the caption state and sets columns to 32; a stalled response
// holds the input register, and req_ready drops only when both registers are full.
module greedy_word_wrap #(
   parameter int unsigned MAX_LINES    = 4,
   parameter int unsigned MAX_TEXT_LEN = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  gww_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output gww_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gww_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [gww_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [gww_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import gww_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_type      in_data_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_type      out_data_ff;
   logic         advance;
   logic [7:0]   columns;
   step_out_type step_out;

   gww_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .columns (columns)
   );

   gww_step #(
      .MAX_LINES    (MAX_LINES),
      .MAX_TEXT_LEN (MAX_TEXT_LEN)
   ) u_step (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .req      (in_data_ff),
      .columns  (columns),
      .step_out (step_out)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = step_out.has_rsp;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (advance && step_out.has_rsp) begin
         out_data_ff <= step_out.rsp;
      end
   end

endmodule
